[design/uart_tx_fifo_serializer_macros.svh]
// Assertion macros used by the UART transmitter checker.
`ifndef UART_TX_FIFO_SERIALIZER_MACROS_SVH
`define UART_TX_FIFO_SERIALIZER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UTFS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("utfs check failed");

// Next-cycle implication, disabled while reset is asserted.
`define UTFS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("utfs check failed");

`endif

[design/utfs_pkg.sv]
// Shared constants and types for the UART transmitter with FIFO.
package utfs_pkg;

    localparam int FIFO_DEPTH  = 128;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int LEVEL_W     = PTR_W;
    localparam int DATA_BITS   = 8;
    localparam int BITCNT_W    = 4;
    localparam int TICK_W      = 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_VALUE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TX_ENABLE     = 1'd1;

    localparam logic [TICK_W-1:0] COMPARE_RESET = 8'd207;
    localparam logic              ENABLE_RESET  = 1'b1;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_PUSH = 1'b1;

    // Classified word handed from the front to the back.
    typedef struct packed {
        logic                 is_push;
        logic [DATA_BITS-1:0] data;
    } utfs_cmd_t;

    // Transmitter configuration seen by the back.
    typedef struct packed {
        logic [TICK_W-1:0] compare_value;
        logic              tx_enable;
    } utfs_cfg_t;

endpackage

[design/utfs_front.sv]
// Front end: accepts input words, classifies them and queues them for the back.
module utfs_front
    import utfs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 req_type,
    input  logic [DATA_BITS-1:0] byte_value,
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output utfs_cmd_t            cmd
);

    utfs_cmd_t         q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              enq;
    logic              deq;
    utfs_cmd_t         cmd_in;

    assign in_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];

    assign enq = in_valid && in_ready;
    assign deq = cmd_valid && cmd_ready;

    always_comb
    begin
        cmd_in.is_push = (req_type == REQ_PUSH);
        cmd_in.data    = byte_value;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (enq)
        begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (deq)
        begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        case ({enq, deq})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

[design/utfs_back.sv]
// Back end: FIFO store, bit timer, serializer and the result register.
module utfs_back
    import utfs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  utfs_cfg_t          cfg,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  utfs_cmd_t          cmd,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               tx_line,
    output logic               push_accepted,
    output logic               busy_res,
    output logic [LEVEL_W-1:0] queue_level
);

    logic [DATA_BITS-1:0] mem [FIFO_DEPTH];
    logic [DATA_BITS-1:0] mem_rdata_reg;

    logic [PTR_W-1:0]     wp_reg;
    logic [PTR_W-1:0]     wp_next;
    logic [PTR_W-1:0]     rp_reg;
    logic [PTR_W-1:0]     rp_next;
    logic [DATA_BITS-1:0] shift_reg;
    logic [DATA_BITS-1:0] shift_next;
    logic [BITCNT_W-1:0]  bit_count_reg;
    logic [BITCNT_W-1:0]  bit_count_next;
    logic                 in_frame_reg;
    logic                 in_frame_next;
    logic [TICK_W-1:0]    tick_count_reg;
    logic [TICK_W-1:0]    tick_count_next;
    logic                 line_level_reg;
    logic                 line_level_next;
    logic                 load_pending_reg;
    logic                 load_pending_next;

    logic                 out_valid_reg;
    logic                 tx_line_reg;
    logic                 push_accepted_reg;
    logic                 busy_reg;
    logic [LEVEL_W-1:0]   level_reg;

    logic                 fire;
    logic                 wr_en;
    logic                 rd_en;
    logic                 accepted;
    logic [PTR_W-1:0]     wp_inc;
    logic [DATA_BITS-1:0] shift_cur;

    assign cmd_ready = !out_valid_reg || out_ready;
    assign fire      = cmd_valid && cmd_ready;
    assign wp_inc    = wp_reg + PTR_W'(1);

    // The head byte arrives from the read port in the cycle after frame start; take it from there then.
    assign shift_cur = load_pending_reg ? mem_rdata_reg : shift_reg;

    always_comb
    begin
        wp_next           = wp_reg;
        rp_next           = rp_reg;
        shift_next        = shift_cur;
        bit_count_next    = bit_count_reg;
        in_frame_next     = in_frame_reg;
        tick_count_next   = tick_count_reg;
        line_level_next   = line_level_reg;
        load_pending_next = 1'b0;
        wr_en             = 1'b0;
        rd_en             = 1'b0;
        accepted          = 1'b0;

        if (fire)
        begin
            if (cmd.is_push)
            begin
                // Drop the byte when the ring is full.
                if (wp_inc != rp_reg)
                begin
                    wr_en    = 1'b1;
                    wp_next  = wp_inc;
                    accepted = 1'b1;
                end
            end
            else if (cfg.tx_enable)
            begin
                if (tick_count_reg == cfg.compare_value)
                begin
                    tick_count_next = '0;
                    if (!in_frame_reg)
                    begin
                        if (wp_reg == rp_reg)
                        begin
                            line_level_next = 1'b1;
                        end
                        else
                        begin
                            rd_en             = 1'b1;
                            load_pending_next = 1'b1;
                            rp_next           = rp_reg + PTR_W'(1);
                            bit_count_next    = '0;
                            in_frame_next     = 1'b1;
                            line_level_next   = 1'b0;
                        end
                    end
                    else if (bit_count_reg < BITCNT_W'(DATA_BITS))
                    begin
                        line_level_next = shift_cur[0];
                        shift_next      = shift_cur >> 1;
                        bit_count_next  = bit_count_reg + BITCNT_W'(1);
                    end
                    else
                    begin
                        line_level_next = 1'b1;
                        in_frame_next   = 1'b0;
                    end
                end
                else
                begin
                    tick_count_next = tick_count_reg + TICK_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg           <= '0;
            rp_reg           <= '0;
            shift_reg        <= '0;
            bit_count_reg    <= '0;
            in_frame_reg     <= 1'b0;
            tick_count_reg   <= '0;
            line_level_reg   <= 1'b1;
            load_pending_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            wp_reg           <= wp_next;
            rp_reg           <= rp_next;
            shift_reg        <= shift_next;
            bit_count_reg    <= bit_count_next;
            in_frame_reg     <= in_frame_next;
            tick_count_reg   <= tick_count_next;
            line_level_reg   <= line_level_next;
            load_pending_reg <= load_pending_next;
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: hold until taken, load on every processed word.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            tx_line_reg       <= line_level_next;
            push_accepted_reg <= accepted;
            busy_reg          <= (wp_next != rp_next) || in_frame_next;
            level_reg         <= wp_next - rp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wp_reg] <= cmd.data;
        end
        if (rd_en)
        begin
            mem_rdata_reg <= mem[rp_reg];
        end
    end

    assign out_valid     = out_valid_reg;
    assign tx_line       = tx_line_reg;
    assign push_accepted = push_accepted_reg;
    assign busy_res      = busy_reg;
    assign queue_level   = level_reg;

endmodule

[design/uart_tx_fifo_serializer.sv]
// Top level of the 8N1 UART transmitter with a ring-buffer FIFO.
// Each input word passes through the front queue and then the back end's result register.
// Throughput: one word per clock while the output is not stalled, set by the back end's per-word state update.
// A two-entry queue and the result register let input and output stall independently.
// Reset (asynchronous, active low) clears pointers, timer, serializer and handshakes;
// the FIFO store is not cleared and needs no clearing pass.
module uart_tx_fifo_serializer
    import utfs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  req_type,
    input  logic [DATA_BITS-1:0]  byte_value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  tx_line,
    output logic                  push_accepted,
    output logic                  busy_res,
    output logic [LEVEL_W-1:0]    queue_level,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [TICK_W-1:0] compare_value_reg;
    logic              tx_enable_reg;
    utfs_cfg_t         cfg;
    utfs_cmd_t         cmd;
    logic              cmd_valid;
    logic              cmd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compare_value_reg <= COMPARE_RESET;
            tx_enable_reg     <= ENABLE_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_COMPARE_VALUE: compare_value_reg <= cfg_data[TICK_W-1:0];
                CFG_TX_ENABLE:     tx_enable_reg     <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        cfg.compare_value = compare_value_reg;
        cfg.tx_enable     = tx_enable_reg;
    end

    utfs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .byte_value (byte_value),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd)
    );

    utfs_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .tx_line       (tx_line),
        .push_accepted (push_accepted),
        .busy_res      (busy_res),
        .queue_level   (queue_level)
    );

endmodule

[design/utfs_checker.sv]
// Port-level checker for the UART transmitter, bound to the top level.
`include "uart_tx_fifo_serializer_macros.svh"

module utfs_checker
    import utfs_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic                  tx_line,
    input logic                  push_accepted,
    input logic                  busy_res,
    input logic [LEVEL_W-1:0]    queue_level
);

    logic               stall;
    logic               level_nz;
    logic [LEVEL_W+2:0] res_word;

    assign stall    = out_valid && !out_ready;
    assign level_nz = (queue_level != '0);
    assign res_word = {tx_line, push_accepted, busy_res, queue_level};

    // Hold a stalled result word.
    `UTFS_ASSERT_NEXT(a_out_hold, clk, rst_n, stall, out_valid && $stable(res_word))

    // Bytes waiting in the FIFO mean the transmitter is busy.
    `UTFS_ASSERT_IMP(a_level_busy, clk, rst_n, out_valid && level_nz, busy_res)

    // A stored push leaves the FIFO nonempty.
    `UTFS_ASSERT_IMP(a_push_busy, clk, rst_n, out_valid && push_accepted, busy_res && level_nz)

    // Outside a frame the line idles high.
    `UTFS_ASSERT_IMP(a_idle_high, clk, rst_n, out_valid && !busy_res, tx_line)

endmodule

bind uart_tx_fifo_serializer utfs_checker u_checker (.*);

[bench/uart_tx_monitor.sv]
// Checker for the UART transmitter: predicts every result word and compares it.
module uart_tx_monitor
    import utfs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic                  req_type,
    input  logic [DATA_BITS-1:0]  byte_value,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic                  tx_line,
    input  logic                  push_accepted,
    input  logic                  busy_res,
    input  logic [LEVEL_W-1:0]    queue_level,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               line;
        logic               accepted;
        logic               busy;
        logic [LEVEL_W-1:0] level;
    } line_status_t;

    line_status_t status_q[$];

    logic [DATA_BITS-1:0] fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]     wr_ptr;
    logic [PTR_W-1:0]     rd_ptr;
    logic [DATA_BITS-1:0] shifter;
    logic [BITCNT_W-1:0]  bits_sent;
    logic                 framing;
    logic [TICK_W-1:0]    tick_cnt;
    logic                 line_q;
    logic [TICK_W-1:0]    compare_q;
    logic                 enable_q;

    task automatic report_mismatch(input string what);
        $display("%0t ns: %s", $realtime, what);
        mismatches++;
    endtask

    // One compare match: start a frame, shift a data bit, or send the stop bit.
    task automatic end_bit_period();
        if (!framing) begin
            if (wr_ptr == rd_ptr) begin
                line_q = 1'b1;
            end
            else begin
                shifter   = fifo_mem[rd_ptr];
                rd_ptr    = rd_ptr + 1'b1;
                bits_sent = '0;
                framing   = 1'b1;
                line_q    = 1'b0;
            end
        end
        else if (bits_sent < DATA_BITS) begin
            line_q    = shifter[0];
            shifter   = shifter >> 1;
            bits_sent = bits_sent + 1'b1;
        end
        else begin
            line_q  = 1'b1;
            framing = 1'b0;
        end
    endtask

    task automatic predict_word(input logic req, input logic [DATA_BITS-1:0] data,
                                output line_status_t st);
        logic took;
        took = 1'b0;
        if (req == REQ_PUSH) begin
            // keep one slot free: drop the push when full
            if (PTR_W'(wr_ptr + 1'b1) != rd_ptr) begin
                fifo_mem[wr_ptr] = data;
                wr_ptr           = wr_ptr + 1'b1;
                took             = 1'b1;
            end
        end
        else if (enable_q) begin
            if (tick_cnt == compare_q) begin
                tick_cnt = '0;
                end_bit_period();
            end
            else begin
                tick_cnt = tick_cnt + 1'b1;
            end
        end
        st.line     = line_q;
        st.accepted = took;
        st.busy     = (wr_ptr != rd_ptr) || framing;
        st.level    = LEVEL_W'(wr_ptr - rd_ptr);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        line_status_t want;
        line_status_t got;
        if (!rst_n) begin
            status_q.delete();
            wr_ptr     = '0;
            rd_ptr     = '0;
            shifter    = '0;
            bits_sent  = '0;
            framing    = 1'b0;
            tick_cnt   = '0;
            line_q     = 1'b1;
            compare_q  = COMPARE_RESET;
            enable_q   = ENABLE_RESET;
            mismatches = 0;
            pending    <= 0;
        end
        else begin
            if (cfg_write_en) begin
                case (cfg_index)
                    CFG_COMPARE_VALUE: compare_q = cfg_data[TICK_W-1:0];
                    CFG_TX_ENABLE:     enable_q  = cfg_data[0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready) begin
                got = '{tx_line, push_accepted, busy_res, queue_level};
                if (status_q.size() == 0) begin
                    report_mismatch("result word with none expected");
                end
                else begin
                    want = status_q.pop_front();
                    if (got.line !== want.line)
                        report_mismatch($sformatf("tx_line %b, expected %b",
                                                  got.line, want.line));
                    if (got.accepted !== want.accepted)
                        report_mismatch($sformatf("push_accepted %b, expected %b",
                                                  got.accepted, want.accepted));
                    if (got.busy !== want.busy)
                        report_mismatch($sformatf("busy_res %b, expected %b",
                                                  got.busy, want.busy));
                    if (got.level !== want.level)
                        report_mismatch($sformatf("queue_level %0d, expected %0d",
                                                  got.level, want.level));
                end
            end
            if (in_valid && in_ready) begin
                predict_word(req_type, byte_value, want);
                status_q.push_back(want);
            end
            pending <= status_q.size();
        end
    end

endmodule

[bench/testbench.sv]
// Top of the UART transmitter bench: clock, reset, stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import utfs_pkg::*;

    localparam int LIMIT_CYCLES = 200000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic                  req_type;
    logic [DATA_BITS-1:0]  byte_value;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  tx_line;
    logic                  push_accepted;
    logic                  busy_res;
    logic [LEVEL_W-1:0]    queue_level;
    logic                  cfg_write_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  steady = 1'b0;
    int                    mismatches;
    int                    pending;

    always #5 clk = ~clk;

    // receiver stalls about 31% of cycles, never during a steady stretch
    always @(posedge clk)
        out_ready <= steady || ($urandom_range(99) >= 31);

    uart_tx_fifo_serializer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .byte_value    (byte_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .tx_line       (tx_line),
        .push_accepted (push_accepted),
        .busy_res      (busy_res),
        .queue_level   (queue_level),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    uart_tx_monitor line_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .byte_value    (byte_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .tx_line       (tx_line),
        .push_accepted (push_accepted),
        .busy_res      (busy_res),
        .queue_level   (queue_level),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    task automatic send_word(input logic req, input logic [DATA_BITS-1:0] data);
        while (!steady && $urandom_range(99) < 31) begin
            in_valid   <= 1'b0;
            req_type   <= 1'($urandom_range(1));
            byte_value <= DATA_BITS'($urandom_range(255));
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= req;
        byte_value <= data;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic run_phase(input int count, input int push_pct);
        for (int i = 0; i < count; i++)
            send_word(($urandom_range(99) < push_pct) ? REQ_PUSH : REQ_TICK,
                      DATA_BITS'($urandom_range(255)));
    endtask

    // Drop valid and wait until every expected word has come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        req_type     = REQ_TICK;
        byte_value   = '0;
        cfg_write_en = 1'b0;
        cfg_index    = CFG_COMPARE_VALUE;
        cfg_data     = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extreme bytes, a couple of ticks at the reset baud setting
        send_word(REQ_PUSH, 8'h00);
        send_word(REQ_PUSH, 8'hFF);
        send_word(REQ_TICK, 8'hA5);
        send_word(REQ_TICK, 8'h5A);
        drain();

        // compare set to 0, below the running counter: the ticks climb without reaching the match
        write_reg(CFG_COMPARE_VALUE, CFG_DATA_W'(0));
        for (int i = 0; i < 21; i++)
            send_word(REQ_TICK, DATA_BITS'($urandom_range(255)));
        drain();

        write_reg(CFG_COMPARE_VALUE, CFG_DATA_W'(1));
        run_phase(100, 30);
        drain();

        // long stretch without gaps; counter climbs without reaching the match
        write_reg(CFG_COMPARE_VALUE, CFG_DATA_W'(200));
        steady <= 1'b1;
        run_phase(140, 5);
        drain();
        steady <= 1'b0;

        // compare below counter: the counter wraps past 255 before matching
        write_reg(CFG_COMPARE_VALUE, CFG_DATA_W'(5));
        run_phase(190, 10);
        drain();

        // frozen transmitter: fill the FIFO and push into it while full
        write_reg(CFG_TX_ENABLE, CFG_DATA_W'(0));
        run_phase(140, 97);
        drain();

        write_reg(CFG_TX_ENABLE, CFG_DATA_W'(1));
        write_reg(CFG_COMPARE_VALUE, CFG_DATA_W'(255));
        run_phase(30, 50);
        drain();

        write_reg(CFG_COMPARE_VALUE, CFG_DATA_W'(0));
        run_phase(60, 20);
        drain();
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
